[rtl/mlr_pkg.sv]
// Shared definitions for the midpoint line rasterizer: slope case codes,
// transaction kind codes and the default coordinate width.
// No dependencies.
package mlr_pkg;

  // Default coordinate width in bits; the top level takes it as a parameter.
  localparam int unsigned CoordBitsDefault = 10;

  // Extra bits that the decision variable and its increments carry beyond
  // the coordinate width.
  localparam int unsigned DecExtraBits = 4;

  // Input transaction kinds.
  localparam logic KindStart   = 1'b0;
  localparam logic KindAdvance = 1'b1;

  // Slope cases. The line is always walked with x not decreasing.
  typedef enum logic [1:0] {
    SLOPE_X_UP   = 2'd0,  // 0 <= dy <= dx, x is the major axis
    SLOPE_Y_UP   = 2'd1,  // dy > dx, y is the major axis
    SLOPE_X_DOWN = 2'd2,  // -dx <= dy < 0, x is the major axis
    SLOPE_Y_DOWN = 2'd3   // dy < -dx, y is the major axis
  } slope_e;

endpackage

[rtl/midpoint_line_rasterizer.sv]
// Top level of the midpoint line rasterizer: input register, setup logic and
// stepping core with its result register. Uses mlr_pkg, mlr_in_reg,
// mlr_setup and mlr_core.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid_i/in_ready_o   | kind_i, start_x_i, start_y_i, end_x_i, end_y_i
//   out     | out_valid_o/out_ready_i | pixel_x_o, pixel_y_o, pixel_valid_o,
//           |                         | last_pixel_o
//
// Every input transaction yields exactly one output transaction, which passes
// through the input register and then the result register. One transaction is
// accepted per cycle while the output is not stalled; the core holds the line
// state and updates it once per transaction.
// Reset (rst_ni low, asynchronous) empties both stages and leaves no line
// active. A stall on the output holds the result register and, through it,
// the input register; the input side keeps taking transactions as long as one
// of the two registers has room.
module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  pixel_valid_o,
  output logic                  last_pixel_o
);

  // The decision variable needs a few bits of headroom over the coordinates:
  // it is bounded by about four times the coordinate range, plus a sign.
  localparam int unsigned DecBits = COORD_BITS + mlr_pkg::DecExtraBits;

  // Input register outputs.
  logic                  stage_valid;
  logic                  stage_ready;
  logic                  stage_kind;
  logic [COORD_BITS-1:0] stage_sx, stage_sy, stage_ex, stage_ey;

  // Setup results for a start transaction.
  logic [COORD_BITS-1:0]     first_x, first_y, stop_x, stop_y;
  mlr_pkg::slope_e           slope_case;
  logic signed [DecBits-1:0] decision, step_straight, step_diagonal;
  logic                      single_point;

  mlr_in_reg #(
    .COORD_BITS(COORD_BITS)
  ) u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .down_ready_i (stage_ready),
    .stage_valid_o(stage_valid),
    .kind_o       (stage_kind),
    .start_x_o    (stage_sx),
    .start_y_o    (stage_sy),
    .end_x_o      (stage_ex),
    .end_y_o      (stage_ey)
  );

  // Setup works on the registered endpoints; its results are only used when
  // the registered transaction is a start.
  mlr_setup #(
    .COORD_BITS(COORD_BITS),
    .DEC_BITS  (DecBits)
  ) u_setup (
    .start_x_i      (stage_sx),
    .start_y_i      (stage_sy),
    .end_x_i        (stage_ex),
    .end_y_i        (stage_ey),
    .first_x_o      (first_x),
    .first_y_o      (first_y),
    .stop_x_o       (stop_x),
    .stop_y_o       (stop_y),
    .slope_case_o   (slope_case),
    .decision_o     (decision),
    .step_straight_o(step_straight),
    .step_diagonal_o(step_diagonal),
    .single_point_o (single_point)
  );

  // The core either loads a new line, takes one midpoint step or, with no line
  // active, reports no pixel, and writes the result into the output register.
  mlr_core #(
    .COORD_BITS(COORD_BITS),
    .DEC_BITS  (DecBits)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_valid_i  (stage_valid),
    .stage_ready_o  (stage_ready),
    .kind_i         (stage_kind),
    .first_x_i      (first_x),
    .first_y_i      (first_y),
    .stop_x_i       (stop_x),
    .stop_y_i       (stop_y),
    .slope_case_i   (slope_case),
    .decision_i     (decision),
    .step_straight_i(step_straight),
    .step_diagonal_i(step_diagonal),
    .single_point_i (single_point),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_valid_o  (pixel_valid_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

[rtl/mlr_in_reg.sv]
// Input register stage of the midpoint line rasterizer.
// Holds one input transaction until the core stage takes it. Uses mlr_pkg.
module mlr_in_reg #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  down_ready_i,
  output logic                  stage_valid_o,
  output logic                  kind_o,
  output logic [COORD_BITS-1:0] start_x_o,
  output logic [COORD_BITS-1:0] start_y_o,
  output logic [COORD_BITS-1:0] end_x_o,
  output logic [COORD_BITS-1:0] end_y_o
);

  logic                  valid_q;
  logic                  kind_q;
  logic [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic                  load;

  // The stage refills in the same cycle in which the core takes its item.
  assign in_ready_o = !valid_q || down_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (down_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q    <= kind_i;
      start_x_q <= start_x_i;
      start_y_q <= start_y_i;
      end_x_q   <= end_x_i;
      end_y_q   <= end_y_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign kind_o        = kind_q;
  assign start_x_o     = start_x_q;
  assign start_y_o     = start_y_q;
  assign end_x_o       = end_x_q;
  assign end_y_o       = end_y_q;

endmodule

[rtl/mlr_setup.sv]
// Line setup logic of the midpoint line rasterizer: endpoint ordering,
// slope case selection and the initial decision variable and increments.
// Purely combinational. Uses mlr_pkg.
module mlr_setup #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDefault,
  parameter int unsigned DEC_BITS   = COORD_BITS + mlr_pkg::DecExtraBits
) (
  input  logic [COORD_BITS-1:0]      start_x_i,
  input  logic [COORD_BITS-1:0]      start_y_i,
  input  logic [COORD_BITS-1:0]      end_x_i,
  input  logic [COORD_BITS-1:0]      end_y_i,
  output logic [COORD_BITS-1:0]      first_x_o,
  output logic [COORD_BITS-1:0]      first_y_o,
  output logic [COORD_BITS-1:0]      stop_x_o,
  output logic [COORD_BITS-1:0]      stop_y_o,
  output mlr_pkg::slope_e            slope_case_o,
  output logic signed [DEC_BITS-1:0] decision_o,
  output logic signed [DEC_BITS-1:0] step_straight_o,
  output logic signed [DEC_BITS-1:0] step_diagonal_o,
  output logic                       single_point_o
);

  localparam int unsigned ExtBits = DEC_BITS - COORD_BITS;

  logic                       swap;
  logic [COORD_BITS-1:0]      x0, y0, x1, y1;
  logic signed [DEC_BITS-1:0] x0_s, y0_s, x1_s, y1_s;
  logic signed [DEC_BITS-1:0] a, b, dy, neg_b;
  logic signed [DEC_BITS-1:0] a2, b2;

  // Walk every line with x not decreasing.
  assign swap = start_x_i > end_x_i;
  assign x0   = swap ? end_x_i   : start_x_i;
  assign y0   = swap ? end_y_i   : start_y_i;
  assign x1   = swap ? start_x_i : end_x_i;
  assign y1   = swap ? start_y_i : end_y_i;

  assign x0_s = signed'({{ExtBits{1'b0}}, x0});
  assign y0_s = signed'({{ExtBits{1'b0}}, y0});
  assign x1_s = signed'({{ExtBits{1'b0}}, x1});
  assign y1_s = signed'({{ExtBits{1'b0}}, y1});

  assign a     = y0_s - y1_s;
  assign b     = x1_s - x0_s;
  assign dy    = y1_s - y0_s;
  assign neg_b = x0_s - x1_s;
  assign a2    = a <<< 1;
  assign b2    = b <<< 1;

  always_comb begin
    if (!dy[DEC_BITS-1] && (dy <= b)) begin
      slope_case_o    = mlr_pkg::SLOPE_X_UP;
      decision_o      = a2 + b;
      step_straight_o = a2;
      step_diagonal_o = a2 + b2;
    end else if (dy > b) begin
      slope_case_o    = mlr_pkg::SLOPE_Y_UP;
      decision_o      = a + b2;
      step_straight_o = b2;
      step_diagonal_o = a2 + b2;
    end else if (dy >= neg_b) begin
      slope_case_o    = mlr_pkg::SLOPE_X_DOWN;
      decision_o      = a2 - b;
      step_straight_o = a2;
      step_diagonal_o = a2 - b2;
    end else begin
      slope_case_o    = mlr_pkg::SLOPE_Y_DOWN;
      decision_o      = a - b2;
      step_straight_o = -b2;
      step_diagonal_o = a2 - b2;
    end
  end

  // The end test runs along the major axis of the chosen case.
  always_comb begin
    case (slope_case_o)
      mlr_pkg::SLOPE_X_UP, mlr_pkg::SLOPE_X_DOWN: single_point_o = (x0 == x1);
      default:                                    single_point_o = (y0 == y1);
    endcase
  end

  assign first_x_o = x0;
  assign first_y_o = y0;
  assign stop_x_o  = x1;
  assign stop_y_o  = y1;

endmodule

[rtl/mlr_core.sv]
// Line state, midpoint step logic and result register of the midpoint line
// rasterizer. Takes setup values from mlr_setup. Uses mlr_pkg.
module mlr_core #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDefault,
  parameter int unsigned DEC_BITS   = COORD_BITS + mlr_pkg::DecExtraBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       stage_valid_i,
  output logic                       stage_ready_o,
  input  logic                       kind_i,
  input  logic [COORD_BITS-1:0]      first_x_i,
  input  logic [COORD_BITS-1:0]      first_y_i,
  input  logic [COORD_BITS-1:0]      stop_x_i,
  input  logic [COORD_BITS-1:0]      stop_y_i,
  input  mlr_pkg::slope_e            slope_case_i,
  input  logic signed [DEC_BITS-1:0] decision_i,
  input  logic signed [DEC_BITS-1:0] step_straight_i,
  input  logic signed [DEC_BITS-1:0] step_diagonal_i,
  input  logic                       single_point_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [COORD_BITS-1:0]      pixel_x_o,
  output logic [COORD_BITS-1:0]      pixel_y_o,
  output logic                       pixel_valid_o,
  output logic                       last_pixel_o
);

  localparam logic [COORD_BITS-1:0] One = COORD_BITS'(1);

  // Line state.
  logic [COORD_BITS-1:0]      cur_x_q, cur_y_q, stop_x_q, stop_y_q;
  logic signed [DEC_BITS-1:0] dec_q, step_s_q, step_d_q;
  mlr_pkg::slope_e            case_q;
  logic                       active_q;

  // Result register.
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
  logic                  pix_valid_q, last_q;

  logic                       take;
  logic                       neg, diag, adv_end;
  logic [COORD_BITS-1:0]      nx, ny;
  logic signed [DEC_BITS-1:0] ndec;

  assign stage_ready_o = !out_valid_q || out_ready_i;
  assign take          = stage_valid_i && stage_ready_o;

  // One midpoint step from the current state.
  assign neg = dec_q[DEC_BITS-1];

  always_comb begin
    case (case_q)
      mlr_pkg::SLOPE_X_UP: begin
        diag    = neg;
        nx      = cur_x_q + One;
        ny      = diag ? cur_y_q + One : cur_y_q;
        adv_end = (nx == stop_x_q);
      end
      mlr_pkg::SLOPE_Y_UP: begin
        diag    = !neg;
        ny      = cur_y_q + One;
        nx      = diag ? cur_x_q + One : cur_x_q;
        adv_end = (ny == stop_y_q);
      end
      mlr_pkg::SLOPE_X_DOWN: begin
        diag    = !neg;
        nx      = cur_x_q + One;
        ny      = diag ? cur_y_q - One : cur_y_q;
        adv_end = (nx == stop_x_q);
      end
      default: begin
        diag    = neg;
        ny      = cur_y_q - One;
        nx      = diag ? cur_x_q + One : cur_x_q;
        adv_end = (ny == stop_y_q);
      end
    endcase
    ndec = dec_q + (diag ? step_d_q : step_s_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      stop_x_q <= '0;
      stop_y_q <= '0;
      dec_q    <= '0;
      step_s_q <= '0;
      step_d_q <= '0;
      case_q   <= mlr_pkg::SLOPE_X_UP;
      active_q <= 1'b0;
    end else if (take) begin
      if (kind_i == mlr_pkg::KindStart) begin
        cur_x_q  <= first_x_i;
        cur_y_q  <= first_y_i;
        stop_x_q <= stop_x_i;
        stop_y_q <= stop_y_i;
        dec_q    <= decision_i;
        step_s_q <= step_straight_i;
        step_d_q <= step_diagonal_i;
        case_q   <= slope_case_i;
        active_q <= !single_point_i;
      end else if (active_q) begin
        cur_x_q  <= nx;
        cur_y_q  <= ny;
        dec_q    <= ndec;
        active_q <= !adv_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (kind_i == mlr_pkg::KindStart) begin
        pix_x_q     <= first_x_i;
        pix_y_q     <= first_y_i;
        pix_valid_q <= 1'b1;
        last_q      <= single_point_i;
      end else if (active_q) begin
        pix_x_q     <= nx;
        pix_y_q     <= ny;
        pix_valid_q <= 1'b1;
        last_q      <= adv_end;
      end else begin
        pix_x_q     <= '0;
        pix_y_q     <= '0;
        pix_valid_q <= 1'b0;
        last_q      <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_valid_o = pix_valid_q;
  assign last_pixel_o  = last_q;

endmodule
